@@ rtl/ilb_pkg.sv @@
// ----------------------------------------------------------------------------
// ilb_pkg: shared types and codes for the indexed list buffer
// Operation and status codes, transfer payload structs and the default depth.
// ----------------------------------------------------------------------------
package ilb_pkg;

  // default number of words in the store
  localparam int unsigned ILB_DEPTH = 256;

  // operation codes
  localparam logic [2:0] FN_PUSH   = 3'd0;
  localparam logic [2:0] FN_POP    = 3'd1;
  localparam logic [2:0] FN_SET    = 3'd2;
  localparam logic [2:0] FN_GET    = 3'd3;
  localparam logic [2:0] FN_REMOVE = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // word returned by a get past the end
  localparam logic signed [31:0] RD_MISS = -32'sd1;

  // one request transfer
  typedef struct packed {
    logic [2:0]         func;
    logic [7:0]         position;
    logic signed [31:0] value;
    logic               keep_order;
  } in_item_t;

  // one result transfer
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [8:0]         count;
    logic [8:0]         reported_capacity;
  } out_item_t;

endpackage

@@ rtl/indexed_list_buffer_core.sv @@
// ----------------------------------------------------------------------------
// indexed_list_buffer_core: packed list of signed words in a one-read, one-write store
// Push, pop, set, get and remove on a list held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: present in_item with start high; the transfer happens on
//   the edge where start is high and busy is low. busy stays high while the
//   request is worked on.
//   Result channel: out_valid strobes for exactly one cycle with out_item;
//   the receiver cannot stall, so it must take the result in that cycle.
//   Every request gives exactly one result.
// Timing:
//   Push, pop, set, get, unordered remove and ordered remove at or past the
//   last word: worked in S_EXEC; the result strobes in the next cycle, when
//   busy is already low, so the next request can be taken as it strobes.
//   Ordered remove at position p below n - 1 with n words held: S_SHIFT moves
//   words p + 1 to n - 1 down, walking the RAM one word a cycle and reading
//   ahead by one entry through the single read port.
// Reset:
//   rst_n (synchronous, active low) empties the list and zeroes the
//   capacity. The RAM is not cleared; words are only ever read below the
//   count, and those were written first.
// ----------------------------------------------------------------------------
module indexed_list_buffer_core
  import ilb_pkg::*;
#(
  parameter int unsigned DEPTH = ILB_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > 8) ? CW : 8) + 1;
  localparam int unsigned RW = (CW > 9) ? CW : 9;
  localparam logic [CW:0] DEPTH_C = (CW + 1)'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SHIFT} state_t;

  state_t          state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   cap_r, cap_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic [31:0]     word_mem [DEPTH];
  logic [31:0]     rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [31:0]     wr_data;

  logic [PW-1:0]   cnt_p, in_pos_p, in_pos1_p, cur_pos_p;
  logic            in_shift, cur_in_range;
  logic            drop_ok, push_ok;
  logic [CW-1:0]   drop_cnt, drop_cap, push_cnt, push_cap;
  logic [CW:0]     grown, grown_lim, ptr_p2;
  logic [AW-1:0]   last_addr;
  logic signed [31:0] res_rv;
  logic [1:0]      res_st;
  logic [RW-1:0]   cnt_rep, cap_rep;

  // position compares, widened so position + 1 cannot wrap
  assign cnt_p        = PW'(count_r);
  assign in_pos_p     = PW'(in_item.position);
  assign in_pos1_p    = in_pos_p + PW'(1);
  assign cur_pos_p    = PW'(item_r.position);
  assign cur_in_range = cur_pos_p < cnt_p;
  assign in_shift     = (in_item.func == FN_REMOVE) && in_item.keep_order &&
                        (in_pos1_p < cnt_p);

  // pop: drop last word, halve capacity once the list falls to half, zero it when empty
  assign drop_ok   = count_r != '0;
  assign drop_cnt  = count_r - CW'(1);
  assign drop_cap  = ({drop_cnt, 1'b0} <= {1'b0, cap_r}) ?
                     ((drop_cnt == '0) ? '0 : (cap_r >> 1)) : cap_r;
  assign last_addr = drop_cnt[AW-1:0];

  // push: grow capacity by doubling, held within the store depth
  assign push_ok   = (CW + 1)'(count_r) < DEPTH_C;
  assign push_cnt  = count_r + CW'(1);
  assign grown     = (cap_r == '0) ? (CW + 1)'(2) : {cap_r, 1'b0};
  assign grown_lim = (grown > DEPTH_C) ? DEPTH_C : grown;
  assign push_cap  = (count_r >= cap_r) ? grown_lim[CW-1:0] : cap_r;

  // shift walk: entry read ahead of the one being written
  assign ptr_p2 = (CW + 1)'(ptr_r) + (CW + 1)'(2);

  // sequencer and read-modify-write control
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_addr       = ptr_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = rd_data_r;
    res_rv        = '0;
    res_st        = ST_IGNORED;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          if (in_item.func == FN_GET) begin
            rd_addr   = in_pos_p[AW-1:0];
            state_nxt = S_EXEC;
          end else if (in_shift) begin
            rd_addr   = in_pos1_p[AW-1:0];
            ptr_nxt   = in_pos_p[AW-1:0];
            state_nxt = S_SHIFT;
          end else begin
            rd_addr   = last_addr;
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        unique case (item_r.func)
          FN_PUSH: begin
            if (push_ok) begin
              wr_en     = 1'b1;
              wr_addr   = count_r[AW-1:0];
              wr_data   = item_r.value;
              count_nxt = push_cnt;
              cap_nxt   = push_cap;
              res_st    = ST_DONE;
            end else begin
              res_st = ST_FULL;
            end
          end
          FN_POP: begin
            if (drop_ok) begin
              count_nxt = drop_cnt;
              cap_nxt   = drop_cap;
              res_st    = ST_DONE;
            end
          end
          FN_SET: begin
            if (cur_in_range) begin
              wr_en   = 1'b1;
              wr_addr = cur_pos_p[AW-1:0];
              wr_data = item_r.value;
              res_st  = ST_DONE;
            end
          end
          FN_GET: begin
            if (cur_in_range) begin
              res_rv = $signed(rd_data_r);
              res_st = ST_DONE;
            end else begin
              res_rv = RD_MISS;
            end
          end
          FN_REMOVE: begin
            // last word moved into the hole, then the end dropped
            if (cur_in_range && (count_r != CW'(1))) begin
              wr_en   = 1'b1;
              wr_addr = cur_pos_p[AW-1:0];
              wr_data = rd_data_r;
            end
            if (drop_ok) begin
              count_nxt = drop_cnt;
              cap_nxt   = drop_cap;
              res_st    = ST_DONE;
            end
          end
          default: begin
            res_st = ST_IGNORED;
          end
        endcase
      end

      S_SHIFT: begin
        // move one word down; read and write never hit the same entry
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data_r;
        if (ptr_p2 >= (CW + 1)'(count_r)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          count_nxt     = drop_cnt;
          cap_nxt       = drop_cap;
          res_st        = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
          rd_addr = ptr_p2[AW-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result word, count and capacity in their low 9 bits
    cnt_rep = RW'(count_nxt);
    cap_rep = RW'(cap_nxt);
    if (out_valid_nxt) begin
      out_item_nxt.read_value        = res_rv;
      out_item_nxt.status            = res_st;
      out_item_nxt.count             = cnt_rep[8:0];
      out_item_nxt.reported_capacity = cap_rep[8:0];
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    ptr_r      <= ptr_nxt;
    out_item_r <= out_item_nxt;
  end

  // word store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= word_mem[rd_addr];
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/ilb_checker.sv @@
// ----------------------------------------------------------------------------
// ilb_checker: port-level checks for the indexed list buffer
// Watches request and result transfers and the busy flag over time.
// ----------------------------------------------------------------------------
module ilb_checker
  import ilb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // a result never shows while a request is still in work
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an accepted request holds the block busy and gives no result next cycle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("request transfer did not raise busy");

  // result strobe lasts one cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a refused push only happens with the list at full capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_FULL)) |->
    (out_item.count == out_item.reported_capacity))
    else $error("full status with count below capacity");

endmodule

bind indexed_list_buffer_core ilb_checker u_ilb_checker (.*);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for indexed_list_buffer_core
// Drives push, pop, set, get and remove requests through the start/busy
// command port: a short table of directed rows first, then phases of random
// traffic that grow the list to full, shrink it and mix all operations. A
// shadow copy of the list predicts the results the table does not give; each
// strobed result is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ilb_pkg::*;

  localparam int unsigned LIST_DEPTH     = ILB_DEPTH;
  localparam int unsigned RANDOM_ITEMS   = 1950;
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam logic [2:0]  FN_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  FN_SPARE_LAST  = 3'd7;

  // traffic shape of one random phase
  typedef enum int {
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIX,
    MODE_FILL
  } load_mode_t;

  // one directed row: request and, where typed in, its result
  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // shadow of the list held in the block
  logic signed [31:0] shadow_words [LIST_DEPTH];
  int unsigned        shadow_count;
  int unsigned        shadow_cap;

  out_item_t   pending_results [$];
  dir_row_t    dir_rows [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          req_live;
  bit          idle_on;

  indexed_list_buffer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // drop the tail word, halving the capacity when the list has shrunk enough
  function automatic logic [1:0] shadow_drop_last();
    if (shadow_count == 0) return ST_IGNORED;
    shadow_count--;
    if (shadow_count * 2 <= shadow_cap)
      shadow_cap = (shadow_count == 0) ? 0 : shadow_cap / 2;
    return ST_DONE;
  endfunction

  // apply one request to the shadow list and return the result it gives
  function automatic out_item_t list_apply(in_item_t req);
    out_item_t   res;
    int unsigned grown;
    int unsigned pos;
    pos            = req.position;
    res.read_value = '0;
    res.status     = ST_IGNORED;
    case (req.func)
      FN_PUSH: begin
        if (shadow_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (shadow_count >= shadow_cap) begin
            grown = (shadow_cap == 0) ? 2 : shadow_cap * 2;
            shadow_cap = (grown > LIST_DEPTH) ? LIST_DEPTH : grown;
          end
          shadow_words[shadow_count] = req.value;
          shadow_count++;
          res.status = ST_DONE;
        end
      end
      FN_POP: res.status = shadow_drop_last();
      FN_SET: begin
        if (pos < shadow_count) begin
          shadow_words[pos] = req.value;
          res.status = ST_DONE;
        end
      end
      FN_GET: begin
        if (pos < shadow_count) begin
          res.read_value = shadow_words[pos];
          res.status     = ST_DONE;
        end else begin
          res.read_value = RD_MISS;
        end
      end
      FN_REMOVE: begin
        if (pos < shadow_count && shadow_count != 1) begin
          if (req.keep_order) begin
            for (int unsigned i = pos; i + 1 < shadow_count; i++)
              shadow_words[i] = shadow_words[i + 1];
          end else begin
            shadow_words[pos] = shadow_words[shadow_count - 1];
          end
        end
        res.status = shadow_drop_last();
      end
      default: ;
    endcase
    res.count             = shadow_count[8:0];
    res.reported_capacity = shadow_cap[8:0];
    return res;
  endfunction

  // one row of the directed table
  function automatic void add_row(logic [2:0] fn, logic [7:0] pos, logic [31:0] val,
                                  bit keep, bit typed, logic [31:0] rd,
                                  logic [1:0] st, logic [8:0] cnt, logic [8:0] cap);
    dir_row_t row;
    row.req.func                = fn;
    row.req.position            = pos;
    row.req.value               = val;
    row.req.keep_order          = keep;
    row.typed                   = typed;
    row.res.read_value          = rd;
    row.res.status              = st;
    row.res.count               = cnt;
    row.res.reported_capacity   = cap;
    dir_rows.push_back(row);
  endfunction

  // random request, weighted by the phase's traffic shape
  function automatic in_item_t make_request(load_mode_t mode);
    in_item_t    req;
    int unsigned roll;
    int unsigned w_push;
    int unsigned w_pop;
    int unsigned w_set;
    int unsigned w_get;
    case (mode)
      MODE_GROW:   begin w_push = 55; w_pop = 5;  w_set = 10; w_get = 15; end
      MODE_SHRINK: begin w_push = 10; w_pop = 30; w_set = 10; w_get = 15; end
      MODE_FILL:   begin w_push = 88; w_pop = 2;  w_set = 4;  w_get = 4;  end
      default:     begin w_push = 25; w_pop = 15; w_set = 15; w_get = 20; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < w_push)                             req.func = FN_PUSH;
    else if (roll < w_push + w_pop)                req.func = FN_POP;
    else if (roll < w_push + w_pop + w_set)        req.func = FN_SET;
    else if (roll < w_push + w_pop + w_set + w_get) req.func = FN_GET;
    else if (roll < 98)                            req.func = FN_REMOVE;
    else req.func = 3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
    // mostly a live position, now and then anything
    if (shadow_count > 0 && $urandom_range(0, 9) != 0)
      req.position = 8'($urandom_range(0, shadow_count - 1));
    else
      req.position = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0:       req.value = 32'h7fff_ffff;
      1:       req.value = 32'h8000_0000;
      2:       req.value = '0;
      3:       req.value = '1;
      default: req.value = $urandom;
    endcase
    req.keep_order = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // present one request, wait for its transfer and record its result
  task automatic send_request(in_item_t req, bit typed, out_item_t typed_res);
    int unsigned gap;
    out_item_t   predicted;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0 || !req_live) begin
      if (req_live) start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_item  <= req;
    req_live  = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = list_apply(req);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // sender holds off until every result has come back
  task automatic hold_until_drained();
    if (req_live) start <= 1'b0;
    req_live = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    load_mode_t  mode;
    int unsigned counted;
    int unsigned phase_len;
    int unsigned phase_idx;
    in_item_t    req;
    start        = 1'b0;
    in_item      = '0;
    rst_n        = 1'b0;
    req_live     = 1'b0;
    idle_on      = 1'b1;
    shadow_count = 0;
    shadow_cap   = 0;
    mismatches   = 0;

    // empty list: every access is ignored, unused codes too
    add_row(FN_POP,         8'd0,   32'd0,        0, 1, 32'd0, ST_IGNORED, 9'd0, 9'd0);
    add_row(FN_GET,         8'd0,   32'd0,        0, 1, '1,    ST_IGNORED, 9'd0, 9'd0);
    add_row(FN_SET,         8'd0,   32'd1,        0, 1, 32'd0, ST_IGNORED, 9'd0, 9'd0);
    add_row(FN_REMOVE,      8'd255, 32'd0,        1, 1, 32'd0, ST_IGNORED, 9'd0, 9'd0);
    add_row(FN_SPARE_FIRST, 8'd0,   32'd0,        0, 1, 32'd0, ST_IGNORED, 9'd0, 9'd0);
    add_row(FN_SPARE_LAST,  8'd255, '1,           1, 1, 32'd0, ST_IGNORED, 9'd0, 9'd0);
    // growth from zero capacity, extreme words
    add_row(FN_PUSH,        8'd0,   32'h7fff_ffff, 0, 1, 32'd0, ST_DONE, 9'd1, 9'd2);
    add_row(FN_PUSH,        8'd0,   32'h8000_0000, 0, 1, 32'd0, ST_DONE, 9'd2, 9'd2);
    add_row(FN_PUSH,        8'd0,   32'd0,         0, 1, 32'd0, ST_DONE, 9'd3, 9'd4);
    add_row(FN_PUSH,        8'd0,   '1,            0, 1, 32'd0, ST_DONE, 9'd4, 9'd4);
    add_row(FN_GET,         8'd0,   32'd0, 0, 1, 32'h7fff_ffff, ST_DONE, 9'd4, 9'd4);
    add_row(FN_GET,         8'd1,   32'd0, 0, 1, 32'h8000_0000, ST_DONE, 9'd4, 9'd4);
    add_row(FN_GET,         8'd3,   32'd0, 0, 1, '1,            ST_DONE, 9'd4, 9'd4);
    // positions at and past the end
    add_row(FN_GET,         8'd4,   32'd0, 0, 1, '1,    ST_IGNORED, 9'd4, 9'd4);
    add_row(FN_GET,         8'd255, 32'd0, 0, 1, '1,    ST_IGNORED, 9'd4, 9'd4);
    add_row(FN_SET,         8'd3,   32'h5555_5555, 0, 0, '0, '0, '0, '0);
    add_row(FN_SET,         8'd4,   32'h1234_5678, 0, 0, '0, '0, '0, '0);
    // ordered and unordered remove, remove past the end, remove of the last word
    add_row(FN_REMOVE,      8'd0,   32'd0, 1, 0, '0, '0, '0, '0);
    add_row(FN_GET,         8'd0,   32'd0, 0, 0, '0, '0, '0, '0);
    add_row(FN_REMOVE,      8'd0,   32'd0, 0, 0, '0, '0, '0, '0);
    add_row(FN_REMOVE,      8'd200, 32'd0, 1, 0, '0, '0, '0, '0);
    add_row(FN_GET,         8'd0,   32'd0, 0, 0, '0, '0, '0, '0);
    add_row(FN_REMOVE,      8'd0,   32'd0, 0, 0, '0, '0, '0, '0);
    add_row(FN_PUSH,        8'd255, 32'haaaa_aaaa, 1, 1, 32'd0, ST_DONE, 9'd1, 9'd2);
    add_row(FN_GET,         8'd0,   32'd0, 0, 0, '0, '0, '0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    hold_until_drained();

    // random phases; the second one is always a fill phase that pushes toward the top
    counted   = 0;
    phase_idx = 0;
    while (counted < RANDOM_ITEMS) begin
      if (phase_idx == 1 || $urandom_range(0, 7) == 0) begin
        mode      = MODE_FILL;
        phase_len = LIST_DEPTH + 80;
      end else begin
        case ($urandom_range(0, 2))
          0:       mode = MODE_GROW;
          1:       mode = MODE_SHRINK;
          default: mode = MODE_MIX;
        endcase
        phase_len = $urandom_range(20, 120);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      for (int unsigned k = 0; k < phase_len && counted < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 49) == 0) hold_until_drained();
        req = make_request(mode);
        send_request(req, 1'b0, '0);
        if (req.func <= FN_REMOVE) counted++;
      end
      phase_idx++;
    end

    // drain and settle
    if (req_live) start <= 1'b0;
    req_live = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** indexed_list_buffer_core: PASSED **");
    end else begin
      $display("** indexed_list_buffer_core: FAILED **");
    end
    $finish;
  end

  // result checker: each strobe against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing predicted: status %0d count %0d",
               out_item.status, out_item.count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_item.read_value);
          mismatches++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatches++;
        end
        if (out_item.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_item.count);
          mismatches++;
        end
        if (out_item.reported_capacity !== want.reported_capacity) begin
          $error("reported_capacity: expected %0d, got %0d",
                 want.reported_capacity, out_item.reported_capacity);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** indexed_list_buffer_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
